FILE: rtl/idss_pkg.sv
// Shared types and codes for the id stack with search and remove.
package idss_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_REMOVE = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_POP   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_SHIFT = 4'b1000
  } state_t;

endpackage

FILE: rtl/idss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module idss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/id_stack_with_search_and_remove_top.sv
// Top level: id stack sequencer around one shared RAM and one id comparator.
//
// A request is taken when start is high and busy is low; its result appears
// for exactly one cycle with out_valid high, and must be taken then. Push
// leaves busy low, so a new request can follow at once. Any request on an
// empty store also answers without going busy. Pop goes busy for one RAM
// read. Search walks the held entries bottom up, one per cycle, until the id
// is found or the top entry has been checked. Remove takes the same walk to
// the first match and then moves every entry above it down one place, one
// per cycle. The single read port of the entry RAM is shared by pop, the
// search walk and the shift. There is no clearing pass after reset: only
// entries below the count are ever used.
module id_stack_with_search_and_remove_top
  import idss_pkg::*;
#(
  parameter int DEPTH   = 64,
  parameter int ID_BITS = 16,
  localparam int CNT_W  = $clog2(DEPTH + 1),
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [ID_BITS-1:0] in_vertex_id,
  output logic               out_valid,
  output logic               out_ok,
  output logic               out_found,
  output logic [ID_BITS-1:0] out_popped_id,
  output logic               out_is_empty,
  output logic [CNT_W-1:0]   out_entry_count
);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ID_BITS-1:0]  key_r, key_nxt;
  logic                op_rm_r, op_rm_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic [CNT_W-1:0]    chk_r, chk_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic [CNT_W-1:0]    src_r, src_nxt;
  logic [ADDR_W-1:0]   wr_a_r, wr_a_nxt;
  logic                wr_v_r, wr_v_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r;
  logic                out_found_r;
  logic [ID_BITS-1:0]  out_popped_id_r;
  logic                out_is_empty_r;
  logic [CNT_W-1:0]    out_entry_count_r;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ID_BITS-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ID_BITS-1:0]  ram_rdata;

  logic [CNT_W-1:0]    cnt_m1;
  logic [CNT_W-1:0]    src_m1;
  logic                hit;
  logic                last;
  logic                fin;
  logic                res_ok;
  logic                res_found;
  logic [ID_BITS-1:0]  res_pop;

  idss_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt_m1 = count_r - CNT_W'(1);
  assign src_m1 = src_r - CNT_W'(1);
  // shared comparator: word on the read port against the key, walk end check
  assign hit    = chk_v_r && (ram_rdata == key_r);
  assign last   = chk_v_r && (chk_r == cnt_m1);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    key_nxt   = key_r;
    op_rm_nxt = op_rm_r;
    scan_nxt  = scan_r;
    chk_nxt   = chk_r;
    chk_v_nxt = chk_v_r;
    src_nxt   = src_r;
    wr_a_nxt  = wr_a_r;
    wr_v_nxt  = wr_v_r;
    ram_we    = 1'b0;
    ram_waddr = count_r[ADDR_W-1:0];
    ram_wdata = in_vertex_id;
    ram_raddr = scan_r[ADDR_W-1:0];
    fin       = 1'b0;
    res_ok    = 1'b0;
    res_found = 1'b0;
    res_pop   = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt = in_vertex_id;
          case (in_action)
            ACT_PUSH: begin
              fin = 1'b1;
              if (count_r != CNT_W'(DEPTH)) begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                res_ok    = 1'b1;
              end
            end
            ACT_POP: begin
              if (count_r != '0) begin
                ram_raddr = cnt_m1[ADDR_W-1:0];
                state_nxt = S_POP;
              end else begin
                fin = 1'b1;
              end
            end
            ACT_SEARCH, ACT_REMOVE: begin
              op_rm_nxt = (in_action == ACT_REMOVE);
              if (count_r == '0) begin
                fin = 1'b1;
              end else begin
                scan_nxt  = '0;
                chk_v_nxt = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_POP: begin
        res_ok    = 1'b1;
        res_pop   = ram_rdata;
        count_nxt = cnt_m1;
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end

      S_SCAN: begin
        if (hit) begin
          if (op_rm_r) begin
            // first match found: pull the entries above it down
            src_nxt   = chk_r + CNT_W'(1);
            wr_v_nxt  = 1'b0;
            state_nxt = S_SHIFT;
          end else begin
            res_found = 1'b1;
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (last) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          scan_nxt  = scan_r + CNT_W'(1);
          chk_nxt   = scan_r;
          chk_v_nxt = 1'b1;
        end
      end

      S_SHIFT: begin
        ram_raddr = src_r[ADDR_W-1:0];
        if (wr_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = wr_a_r;
          ram_wdata = ram_rdata;
        end
        if (src_r < count_r) begin
          wr_a_nxt = src_m1[ADDR_W-1:0];
          wr_v_nxt = 1'b1;
          src_nxt  = src_r + CNT_W'(1);
        end else begin
          wr_v_nxt = 1'b0;
          // finish once the last pending word has been written back
          if (!wr_v_r) begin
            count_nxt = cnt_m1;
            res_ok    = 1'b1;
            res_found = 1'b1;
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      chk_v_r     <= 1'b0;
      wr_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_v_r     <= chk_v_nxt;
      wr_v_r      <= wr_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    op_rm_r <= op_rm_nxt;
    scan_r  <= scan_nxt;
    chk_r   <= chk_nxt;
    src_r   <= src_nxt;
    wr_a_r  <= wr_a_nxt;
    if (fin) begin
      out_ok_r          <= res_ok;
      out_found_r       <= res_found;
      out_popped_id_r   <= res_pop;
      out_is_empty_r    <= (count_nxt == '0);
      out_entry_count_r <= count_nxt;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_found       = out_found_r;
  assign out_popped_id   = out_popped_id_r;
  assign out_is_empty    = out_is_empty_r;
  assign out_entry_count = out_entry_count_r;

endmodule

FILE: rtl/idss_chk.sv
// Port-level assertions for the id stack, bound to the top level.
module idss_chk
  import idss_pkg::*;
#(
  parameter int DEPTH   = 64,
  parameter int ID_BITS = 16,
  localparam int CNT_W  = $clog2(DEPTH + 1)
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [1:0]         in_action,
  input logic               out_valid,
  input logic               out_ok,
  input logic               out_found,
  input logic [ID_BITS-1:0] out_popped_id,
  input logic               out_is_empty,
  input logic [CNT_W-1:0]   out_entry_count
);

  // every accepted request either goes busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither busy nor answered");

  // push answers in the next cycle and leaves busy low
  a_push_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == ACT_PUSH) |=> (out_valid && !busy))
    else $error("push did not answer in one cycle");

  // leaving busy always delivers the word
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_is_empty == (out_entry_count == '0))
                   && (out_entry_count <= CNT_W'(DEPTH))))
    else $error("empty flag or entry count inconsistent");

  a_popped_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_popped_id != '0) |-> (out_ok && !out_found))
    else $error("popped id on a failed or non-pop result");

endmodule

bind id_stack_with_search_and_remove_top idss_chk #(
  .DEPTH   (DEPTH),
  .ID_BITS (ID_BITS)
) u_idss_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_action       (in_action),
  .out_valid       (out_valid),
  .out_ok          (out_ok),
  .out_found       (out_found),
  .out_popped_id   (out_popped_id),
  .out_is_empty    (out_is_empty),
  .out_entry_count (out_entry_count)
);

FILE: test/idss_reply_checker.sv
// Reply checker for the id stack: mirrors the stack and compares every reply word.
`timescale 1ns / 1ps
module idss_reply_checker
  import idss_pkg::*;
#(
  parameter int DEPTH   = 64,
  parameter int ID_BITS = 16,
  localparam int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_action,
  input  logic [ID_BITS-1:0] in_vertex_id,
  input  logic               out_valid,
  input  logic               out_ok,
  input  logic               out_found,
  input  logic [ID_BITS-1:0] out_popped_id,
  input  logic               out_is_empty,
  input  logic [CNT_W-1:0]   out_entry_count,
  output int                 mismatch_count,
  output int                 owed_count,
  output int                 reply_count,
  output int                 refused_pushes
);

  typedef struct packed {
    logic               ok;
    logic               found;
    logic [ID_BITS-1:0] popped_id;
    logic               is_empty;
    logic [CNT_W-1:0]   entry_count;
  } reply_t;

  logic [ID_BITS-1:0] held_ids [DEPTH];
  int                 held_count = 0;
  reply_t             owed_replies [$];
  int                 bad_total = 0;
  int                 replies_seen = 0;
  int                 refusals = 0;

  // Lowest position holding id, or held_count when absent.
  function automatic int lowest_match(logic [ID_BITS-1:0] id);
    for (int i = 0; i < held_count; i++) begin
      if (held_ids[i] == id) return i;
    end
    return held_count;
  endfunction

  // Apply one request to the mirrored stack and return the reply it owes.
  function automatic reply_t stack_reply(action_t act, logic [ID_BITS-1:0] id);
    reply_t r;
    int     pos;
    r = '0;
    case (act)
      ACT_PUSH: begin
        if (held_count < DEPTH) begin
          held_ids[held_count] = id;
          held_count++;
          r.ok = 1'b1;
        end else begin
          refusals++;
        end
      end
      ACT_POP: begin
        if (held_count > 0) begin
          held_count--;
          r.popped_id = held_ids[held_count];
          r.ok        = 1'b1;
        end
      end
      ACT_SEARCH: begin
        r.found = (lowest_match(id) < held_count);
      end
      default: begin
        pos = lowest_match(id);
        if (pos < held_count) begin
          // close the gap: everything above the match moves down one place
          for (int i = pos; i + 1 < held_count; i++) begin
            held_ids[i] = held_ids[i + 1];
          end
          held_count--;
          r.ok    = 1'b1;
          r.found = 1'b1;
        end
      end
    endcase
    r.is_empty    = (held_count == 0);
    r.entry_count = CNT_W'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      held_count = 0;
      owed_replies.delete();
    end else begin
      if (start && !busy) begin
        owed_replies.push_back(stack_reply(action_t'(in_action), in_vertex_id));
      end
      if (out_valid) begin
        replies_seen++;
        got = {out_ok, out_found, out_popped_id, out_is_empty, out_entry_count};
        if (owed_replies.size() == 0) begin
          bad_total++;
          if (bad_total <= 10) begin
            $display("ERROR: reply word with no request outstanding:");
            $display("       ok=%b found=%b popped=%h empty=%b count=%0d",
                     got.ok, got.found, got.popped_id, got.is_empty, got.entry_count);
          end
        end else begin
          want = owed_replies.pop_front();
          if (got.ok !== want.ok || got.found !== want.found ||
              got.popped_id !== want.popped_id || got.is_empty !== want.is_empty ||
              got.entry_count !== want.entry_count) begin
            bad_total++;
            if (bad_total <= 10) begin
              $display("ERROR: reply word %0d mismatch", replies_seen);
              $display("       expected ok=%b found=%b popped=%h empty=%b count=%0d",
                       want.ok, want.found, want.popped_id, want.is_empty,
                       want.entry_count);
              $display("       got      ok=%b found=%b popped=%h empty=%b count=%0d",
                       got.ok, got.found, got.popped_id, got.is_empty, got.entry_count);
            end
          end
        end
      end
    end
    mismatch_count <= bad_total;
    owed_count     <= owed_replies.size();
    reply_count    <= replies_seen;
    refused_pushes <= refusals;
  end

endmodule

FILE: test/id_stack_with_search_and_remove_top_tb.sv
// Testbench top: clock, reset and request stimulus for the id stack, plus the verdict.
`timescale 1ns / 1ps
module id_stack_with_search_and_remove_top_tb;
  import idss_pkg::*;

  localparam int DEPTH       = 64;
  localparam int ID_BITS     = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int PHASE_WORDS = 360;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_action;
  logic [ID_BITS-1:0] in_vertex_id;
  logic               out_valid;
  logic               out_ok;
  logic               out_found;
  logic [ID_BITS-1:0] out_popped_id;
  logic               out_is_empty;
  logic [CNT_W-1:0]   out_entry_count;

  int mismatch_count;
  int owed_count;
  int reply_count;
  int refused_pushes;
  int cycle_count = 0;
  int idle_pct    = 0;
  int sent_total  = 0;
  int sent_by_action [4];

  always #2 clk = ~clk;

  id_stack_with_search_and_remove_top #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_vertex_id    (in_vertex_id),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_found       (out_found),
    .out_popped_id   (out_popped_id),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count)
  );

  idss_reply_checker #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_reply_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_vertex_id    (in_vertex_id),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_found       (out_found),
    .out_popped_id   (out_popped_id),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count),
    .mismatch_count  (mismatch_count),
    .owed_count      (owed_count),
    .reply_count     (reply_count),
    .refused_pushes  (refused_pushes)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: run timed out after %0d cycles, %0d replies outstanding",
               cycle_count, owed_count);
      $display("id_stack_with_search_and_remove_top test failed");
      $finish;
    end
  end

  // Idle for a random stretch, then issue one request word and hold it
  // until the stack takes it.
  task automatic send_word(action_t act, logic [ID_BITS-1:0] id);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_action    <= act;
    in_vertex_id <= id;
    do @(posedge clk); while (busy);
    sent_total++;
    sent_by_action[act]++;
  endtask

  // Drop start and hold off until every reply owed has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (owed_count != 0);
  endtask

  // Mostly small ids so search and remove hit held entries and duplicates.
  function automatic logic [ID_BITS-1:0] pick_id();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2, 3:    return ID_BITS'($urandom);
      default: return ID_BITS'($urandom_range(0, 15));
    endcase
  endfunction

  initial begin
    int push_pct;
    int seg_len;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_action    = ACT_PUSH;
    in_vertex_id = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-stack corner cases, extreme ids, duplicates, absent ids.
    send_word(ACT_POP, 16'h0000);
    send_word(ACT_SEARCH, 16'h0000);
    send_word(ACT_REMOVE, 16'h0000);
    send_word(ACT_PUSH, 16'h0000);
    send_word(ACT_PUSH, 16'hffff);
    send_word(ACT_PUSH, 16'h0000);
    send_word(ACT_PUSH, 16'h8001);
    send_word(ACT_PUSH, 16'h7ffe);
    send_word(ACT_SEARCH, 16'h0000);
    send_word(ACT_SEARCH, 16'hffff);
    send_word(ACT_SEARCH, 16'h7ffe);
    send_word(ACT_SEARCH, 16'h1234);
    send_word(ACT_REMOVE, 16'h0000);
    send_word(ACT_SEARCH, 16'h0000);
    send_word(ACT_REMOVE, 16'h1234);
    send_word(ACT_REMOVE, 16'h7ffe);
    send_word(ACT_POP, 16'hffff);
    send_word(ACT_POP, 16'h0000);
    send_word(ACT_POP, 16'h0000);
    send_word(ACT_POP, 16'h0000);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       idle_pct = 14;
        1:       idle_pct = 63;
        default: idle_pct = 0;
      endcase
      for (int seg = 0; seg * 60 < PHASE_WORDS; seg++) begin
        // one segment per phase fills the stack past full
        if (seg == 1) begin
          push_pct = 100;
          seg_len  = DEPTH + 4;
        end else begin
          seg_len = 60;
          case ($urandom_range(0, 3))
            0:       push_pct = 15;
            1:       push_pct = 45;
            2:       push_pct = 60;
            default: push_pct = 85;
          endcase
        end
        for (int n = 0; n < seg_len; n++) begin
          if ($urandom_range(0, 99) < push_pct) begin
            send_word(ACT_PUSH, pick_id());
          end else begin
            send_word(action_t'($urandom_range(1, 3)), pick_id());
          end
        end
      end
      wait_drained();
    end

    repeat (80) @(posedge clk);
    $display("Sent %0d requests (push %0d, pop %0d, search %0d, remove %0d)",
             sent_total, sent_by_action[ACT_PUSH], sent_by_action[ACT_POP],
             sent_by_action[ACT_SEARCH], sent_by_action[ACT_REMOVE]);
    $display("under three idle mixes; checked %0d reply words, %0d full-stack refusals.",
             reply_count, refused_pushes);
    if (mismatch_count == 0 && owed_count == 0) begin
      $display("id_stack_with_search_and_remove_top test passed");
    end else begin
      $display("id_stack_with_search_and_remove_top test failed");
    end
    $finish;
  end

endmodule
